### rtl/assert_macros.svh
// Assertion macros for the RTL of the inside-measure block, included by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

### rtl/tcim_pkg.sv
// Package: widths, constants and shared types of the inside-measure block.
`timescale 1ns / 1ps

package tcim_pkg;

  // Payload widths
  localparam int unsigned CoordW = 16;
  localparam int unsigned OutW   = 18;
  localparam int unsigned StepW  = 6;

  // Internal widths
  localparam int unsigned AbsW   = CoordW + 1;   // |coord| up to 2^15
  localparam int unsigned SumW   = AbsW;         // |x|+|y|+|z| <= 98304
  localparam int unsigned NumW   = 21;           // 20 * sum <= 1966080
  localparam int unsigned QuoW   = NumW;         // floor(num / d) < 2^21
  localparam int unsigned DivW   = StepW;        // d = |60 - step| <= 60
  localparam int unsigned CalcW  = 23;           // signed term width
  localparam int unsigned ProdW  = NumW + 28;

  // Reciprocal: recip = ceil(2^RecipShift / d), exact for num < 2^21, d <= 60
  localparam int unsigned RecipShift = 27;
  localparam int unsigned RecipW     = RecipShift + 1;
  localparam int unsigned CntW       = 5;

  // Step value where the corner planes vanish (G = 3)
  localparam logic [StepW-1:0] StepNoPlane = 6'd60;

  // Output saturation bounds
  localparam logic signed [CalcW-1:0] OutMin = -23'sd131072;
  localparam logic signed [CalcW-1:0] OutMax = 23'sd131071;

  // Reciprocal unit status toward the datapath
  typedef struct packed {
    logic              busy;
    logic              plane_en;
    logic [RecipW-1:0] recip;
  } recip_t;

endpackage

### rtl/tcim_if.sv
// Valid/ready channel interfaces: point input and measure output.
`timescale 1ns / 1ps

interface tcim_point_if;
  import tcim_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] coord_x;
  logic signed [CoordW-1:0] coord_y;
  logic signed [CoordW-1:0] coord_z;

  modport source (output valid, output coord_x, output coord_y, output coord_z,
                  input ready);
  modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                  output ready);
endinterface

interface tcim_measure_if;
  import tcim_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [OutW-1:0] inside_measure;

  modport source (output valid, output inside_measure, input ready);
  modport sink   (input valid, input inside_measure, output ready);
endinterface

### rtl/tcim_recip.sv
// Truncation register and serial reciprocal unit for the shared plane divisor.
`timescale 1ns / 1ps

module tcim_recip (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tcim_pkg::StepW-1:0]  cfg_wdata_i,
  output tcim_pkg::recip_t            recip_o
);
  import tcim_pkg::*;

  logic [DivW-1:0]       dvsr_q, dvsr_new;
  logic [DivW-1:0]       rem_q, rem_d;
  logic [RecipShift-1:0] quo_q, quo_d;
  logic [CntW-1:0]       cnt_q;
  logic                  busy_q;
  logic                  plane_en_q;
  logic [RecipW-1:0]     recip_q;
  logic [DivW:0]         trial;
  logic                  fits;

  // d = |60 - step|
  assign dvsr_new = (cfg_wdata_i > StepNoPlane) ? (cfg_wdata_i - StepNoPlane)
                                                : (StepNoPlane - cfg_wdata_i);

  // Restoring step: dividend is 2^27 - 1, so every shifted-in bit is one
  assign trial = {rem_q, 1'b1};
  assign fits  = (trial >= {1'b0, dvsr_q});
  assign rem_d = fits ? DivW'(trial - {1'b0, dvsr_q}) : trial[DivW-1:0];
  assign quo_d = {quo_q[RecipShift-2:0], fits};

  // Control: reset acts like a write of step zero (d = 60)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvsr_q     <= StepNoPlane;
      busy_q     <= 1'b1;
      plane_en_q <= 1'b1;
      cnt_q      <= '0;
    end else if (cfg_we_i) begin
      dvsr_q     <= dvsr_new;
      busy_q     <= (dvsr_new != '0);
      plane_en_q <= (dvsr_new != '0);
      cnt_q      <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (cnt_q == CntW'(RecipShift - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Divider datapath; ceil(2^27/d) = floor((2^27-1)/d) + 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      quo_q   <= '0;
      recip_q <= '0;
    end else if (cfg_we_i) begin
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      if (cnt_q == CntW'(RecipShift - 1)) begin
        recip_q <= {1'b0, quo_d} + RecipW'(1);
      end
    end
  end

  assign recip_o.busy     = busy_q;
  assign recip_o.plane_en = plane_en_q;
  assign recip_o.recip    = recip_q;

endmodule

### rtl/tcim_datapath.sv
// Per-point pipeline: input register, term stage, reciprocal product, result register.
`timescale 1ns / 1ps

module tcim_datapath #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tcim_pkg::recip_t     recip_i,
  tcim_point_if.sink           point_i,
  tcim_measure_if.source       measure_o
);
  import tcim_pkg::*;

  localparam logic signed [CalcW-1:0] One = CalcW'(1) << FRAC_BITS;

  // Stage valids and per-stage ready chain
  logic v0_q, v1_q, v2_q, vo_q;
  logic rdy0, rdy1, rdy2, rdyo;

  assign rdyo = !vo_q || measure_o.ready;
  assign rdy2 = !v2_q || rdyo;
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;

  assign point_i.ready = rdy0 && !recip_i.busy;

  // Stage 0: input register
  logic signed [CoordW-1:0] x_q, y_q, z_q;

  // Stage 1: absolute values, axis term, scaled sum
  logic [AbsW-1:0]          ax, ay, az, amax_xy, amax;
  logic signed [AbsW-1:0]   xs, ys, zs;
  logic [SumW-1:0]          sum;
  logic [NumW-1:0]          num, num_q;
  logic signed [CalcW-1:0]  axis, axis1_q, axis2_q;

  assign xs = {x_q[CoordW-1], x_q};
  assign ys = {y_q[CoordW-1], y_q};
  assign zs = {z_q[CoordW-1], z_q};
  assign ax = xs[AbsW-1] ? AbsW'(-xs) : AbsW'(xs);
  assign ay = ys[AbsW-1] ? AbsW'(-ys) : AbsW'(ys);
  assign az = zs[AbsW-1] ? AbsW'(-zs) : AbsW'(zs);

  assign amax_xy = (ay > ax) ? ay : ax;
  assign amax    = (az > amax_xy) ? az : amax_xy;
  assign axis    = One - $signed({{(CalcW-AbsW){1'b0}}, amax});

  // 20 * sum = 16 * sum + 4 * sum
  assign sum = ax + ay + az;
  assign num = {sum, 4'b0} + {2'b0, sum, 2'b0};

  // Stage 2: quotient by reciprocal multiply
  logic [ProdW-1:0] prod;
  logic [QuoW-1:0]  quo, quo_q;

  assign prod = {{(ProdW-NumW){1'b0}}, num_q} * {{(ProdW-RecipW){1'b0}}, recip_i.recip};
  assign quo  = prod[RecipShift +: QuoW];

  // Stage 3: least term and saturation
  logic signed [CalcW-1:0] plane, best;
  logic signed [OutW-1:0]  result, result_q;

  assign plane = One - $signed({{(CalcW-QuoW){1'b0}}, quo_q});
  assign best  = (recip_i.plane_en && (plane < axis2_q)) ? plane : axis2_q;

  always_comb begin
    if (best < OutMin) begin
      result = OutMin[OutW-1:0];
    end else if (best > OutMax) begin
      result = OutMax[OutW-1:0];
    end else begin
      result = best[OutW-1:0];
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= point_i.valid && point_i.ready;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdyo) vo_q <= v2_q;
    end
  end

  // Payload registers, loaded when a stage takes a transfer
  always_ff @(posedge clk_i) begin
    if (point_i.valid && point_i.ready) begin
      x_q <= point_i.coord_x;
      y_q <= point_i.coord_y;
      z_q <= point_i.coord_z;
    end
    if (v0_q && rdy1) begin
      num_q   <= num;
      axis1_q <= axis;
    end
    if (v1_q && rdy2) begin
      quo_q   <= quo;
      axis2_q <= axis1_q;
    end
    if (v2_q && rdyo) begin
      result_q <= result;
    end
  end

  assign measure_o.valid          = vo_q;
  assign measure_o.inside_measure = result_q;

endmodule

### rtl/truncated_cube_inside_measure_unit.sv
// Top level of the truncated-cube inside-measure block.
// Usage:
//   point_i   : valid/ready sink; one transfer carries coord_x/y/z (Q.12 signed).
//   measure_o : valid/ready source; one transfer carries inside_measure (18 bit,
//               Q.12 signed, saturated), one result per point, in order.
//   cfg_we_i/cfg_wdata_i : write of the truncation step (G = step / 20).
// Throughput: one point per cycle when not stalled, set by the four-register pipeline
// (input register, term and product registers, result register).
// Reset (and every step write with a nonzero divisor) starts a serial
// reciprocal computation of |60 - step|, one quotient bit per cycle:
// point_i.ready stays low until it finishes. Reset loads step zero.
// Output stall: each stage has its own valid bit, so points keep entering
// while empty stages remain; ready drops only when all stages are full.
// Step 60 (G = 3) drops the corner-plane terms; only the axis terms count.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module truncated_cube_inside_measure_unit #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tcim_pkg::StepW-1:0]  cfg_wdata_i,
  tcim_point_if.sink                  point_i,
  tcim_measure_if.source              measure_o
);
  import tcim_pkg::*;

  recip_t recip;

  // Step register and divisor reciprocal
  tcim_recip u_recip (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .recip_o     (recip)
  );

  // Point pipeline
  tcim_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .recip_i   (recip),
    .point_i   (point_i),
    .measure_o (measure_o)
  );

  // No point enters while the reciprocal is being computed
  `ASSERT_IMPLIES(a_busy_blocks_input, clk_i, rst_ni, recip.busy, !point_i.ready)
  // A step write with a nonzero divisor restarts the reciprocal unit
  `ASSERT_NEXT(a_cfg_starts_recip, clk_i, rst_ni, cfg_we_i && (cfg_wdata_i != StepNoPlane), recip.busy)
  // A finished reciprocal for an active plane divisor is never zero
  `ASSERT_IMPLIES(a_recip_nonzero, clk_i, rst_ni, !recip.busy && recip.plane_en, recip.recip != '0)

endmodule

### bench/truncated_cube_inside_measure_unit_test.sv
// Self-checking bench for the truncated-cube inside-measure unit: edge-case and random points.
`timescale 1ns / 1ps

module truncated_cube_inside_measure_unit_test;
  import tcim_pkg::*;

  localparam int FracBits     = 12;
  localparam int StepsPerUnit = 20;          // G = step / 20
  localparam int LimitCycles  = 200000;
  localparam int LongHold     = 80;
  localparam int PhaseItems   = 145;
  localparam int NumPhases    = 12;
  localparam int NumDirected  = 18;
  localparam int ShownFails   = 10;
  localparam longint MeasureMin = -(longint'(1) <<< (OutW - 1));
  localparam longint MeasureMax = (longint'(1) <<< (OutW - 1)) - 1;

  typedef struct {
    logic signed [CoordW-1:0] x, y, z;
  } point_t;

  typedef struct {
    point_t                 pt;
    logic [StepW-1:0]       step;
    logic signed [OutW-1:0] measure;
  } measure_due_t;

  logic             clk_i;
  logic             rst_ni    = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [StepW-1:0] cfg_wdata = '0;

  tcim_point_if   point_ch ();
  tcim_measure_if measure_ch ();

  truncated_cube_inside_measure_unit #(
    .FRAC_BITS (FracBits)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .point_i     (point_ch),
    .measure_o   (measure_ch)
  );

  // Points waiting for the driver, and measures waiting for the output transfer
  point_t       point_queue[$];
  measure_due_t due_measures[$];

  logic [StepW-1:0] active_step = '0;
  point_t           next_point;
  measure_due_t     oldest;

  bit point_taken    = 1'b0;
  bit send_idle      = 1'b0;
  bit recv_idle      = 1'b0;
  bit want_long_hold = 1'b0;
  bit long_hold_done = 1'b0;
  int send_gap        = 0;
  int recv_stall_left = 0;
  int long_hold_left  = 0;

  int points_queued   = 0;
  int points_accepted = 0;
  int results_checked = 0;
  int fail_count      = 0;
  int saturated_count = 0;
  int axis_only_count = 0;
  int steps_written   = 0;
  int cycle_count     = 0;

  // Clock: 2 ns period
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Inside measure of one point at a given truncation step
  function automatic logic signed [OutW-1:0] predict_measure(point_t p,
                                                             logic [StepW-1:0] step);
    longint ax, ay, az, peak, best, divisor, plane;
    ax = (p.x < 0) ? -longint'(p.x) : longint'(p.x);
    ay = (p.y < 0) ? -longint'(p.y) : longint'(p.y);
    az = (p.z < 0) ? -longint'(p.z) : longint'(p.z);
    peak = ax;
    if (ay > peak) peak = ay;
    if (az > peak) peak = az;
    best = (longint'(1) <<< FracBits) - peak;
    // corner planes share one divisor; none at G = 3
    divisor = longint'(StepNoPlane) - longint'(step);
    if (divisor < 0) divisor = -divisor;
    if (divisor != 0) begin
      plane = (longint'(1) <<< FracBits) - (StepsPerUnit * (ax + ay + az)) / divisor;
      if (plane < best) best = plane;
    end
    if (best < MeasureMin) best = MeasureMin;
    if (best > MeasureMax) best = MeasureMax;
    return best[OutW-1:0];
  endfunction

  // Coordinate mix: full range, near the unit cube, extremes, near +-1, near zero
  function automatic logic signed [CoordW-1:0] pick_coord();
    logic signed [CoordW-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = CoordW'($urandom());
      4, 5, 6:    v = CoordW'(int'($urandom_range(0, 12288)) - 6144);
      7: begin
        case ($urandom_range(0, 3))
          0:       v = 16'sh7fff;
          1:       v = 16'sh8000;
          2:       v = '0;
          default: v = -16'sd1;
        endcase
      end
      8:       v = CoordW'(($urandom_range(0, 1) ? 4096 : -4096)
                           + int'($urandom_range(0, 16)) - 8);
      default: v = CoordW'(int'($urandom_range(0, 2)) - 1);
    endcase
    return v;
  endfunction

  task automatic queue_point(int x, int y, int z);
    point_t p;
    p.x = CoordW'(x);
    p.y = CoordW'(y);
    p.z = CoordW'(z);
    point_queue.push_back(p);
    points_queued++;
  endtask

  // Register write, only while nothing is in flight
  task automatic write_step(logic [StepW-1:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we      <= 1'b0;
    active_step = value;
    steps_written++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (points_accepted != points_queued || due_measures.size() != 0) @(negedge clk_i);
  endtask

  // Driver: next point after each transfer, with optional gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      point_ch.valid   <= 1'b0;
      point_ch.coord_x <= '0;
      point_ch.coord_y <= '0;
      point_ch.coord_z <= '0;
    end else if (!point_ch.valid || point_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        point_ch.valid <= 1'b0;
      end else if (point_queue.size() > 0) begin
        next_point       = point_queue.pop_front();
        point_ch.valid   <= 1'b1;
        point_ch.coord_x <= next_point.x;
        point_ch.coord_y <= next_point.y;
        point_ch.coord_z <= next_point.z;
        if (send_idle && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 7);
      end else begin
        point_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: one long hold-off on request, else random stall bursts
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      measure_ch.ready <= 1'b0;
    end else if (long_hold_left > 0) begin
      long_hold_left--;
      measure_ch.ready <= 1'b0;
    end else if (want_long_hold && !long_hold_done) begin
      long_hold_done = 1'b1;
      long_hold_left = LongHold - 1;
      measure_ch.ready <= 1'b0;
    end else if (recv_stall_left > 0) begin
      recv_stall_left--;
      measure_ch.ready <= 1'b0;
    end else if (recv_idle && $urandom_range(0, 5) == 0) begin
      recv_stall_left = $urandom_range(0, 6);
      measure_ch.ready <= 1'b0;
    end else begin
      measure_ch.ready <= 1'b1;
    end
  end

  // Monitor: predict on each point transfer, check each measure transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      point_taken <= 1'b0;
    end else begin
      point_taken <= point_ch.valid && point_ch.ready;
      if (point_ch.valid && point_ch.ready) begin
        oldest.pt.x    = point_ch.coord_x;
        oldest.pt.y    = point_ch.coord_y;
        oldest.pt.z    = point_ch.coord_z;
        oldest.step    = active_step;
        oldest.measure = predict_measure(oldest.pt, active_step);
        due_measures.push_back(oldest);
        points_accepted++;
      end
      if (measure_ch.valid && measure_ch.ready) begin
        results_checked++;
        if (due_measures.size() == 0) begin
          if (fail_count < ShownFails)
            $display("[%0t] measure %0d with no point outstanding", $realtime,
                     measure_ch.inside_measure);
          fail_count++;
        end else begin
          oldest = due_measures.pop_front();
          if (measure_ch.inside_measure !== oldest.measure) begin
            if (fail_count < ShownFails)
              $display("[%0t] point (%0d,%0d,%0d) step %0d: measure %0d, expected %0d",
                       $realtime, oldest.pt.x, oldest.pt.y, oldest.pt.z, oldest.step,
                       measure_ch.inside_measure, oldest.measure);
            fail_count++;
          end
          if (longint'(oldest.measure) == MeasureMin) saturated_count++;
          if (oldest.step == StepNoPlane) axis_only_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LimitCycles) begin
      $display("Run stopped after %0d cycles with %0d measures outstanding",
               cycle_count, due_measures.size());
      $display("truncated_cube_inside_measure_unit_test NOT OK");
      $finish;
    end
  end

  // Stimulus: directed points at the reset step, then one random phase per step
  initial begin : stimulus
    int step_plan [NumPhases] = '{0, 20, 40, 60, 63, 41, 59, 61, 1, 0, 30, 40};
    int directed [NumDirected][3] = '{
      '{0, 0, 0},           '{4096, 0, 0},          '{0, -4096, 0},
      '{0, 0, 4096},        '{32767, 32767, 32767}, '{-32768, -32768, -32768},
      '{-32768, 0, 0},      '{0, 32767, 0},         '{0, 0, -32768},
      '{1, -1, 1},          '{-1, 1, -1},           '{2048, 2048, 2048},
      '{-1365, 1365, -1365}, '{4096, 4096, 4096},   '{8192, -4096, 0},
      '{100, -200, 300},    '{-32768, 32767, -32768}, '{4095, -4097, 12}
    };
    int phase, i;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (phase = 0; phase < NumPhases; phase++) begin
      if (phase > 0) write_step(StepW'(step_plan[phase]));
      @(posedge clk_i);
      // phase 1 keeps the sender busy against a long receiver hold-off
      send_idle = (phase != 1) && (phase != NumPhases - 1) && ($urandom_range(0, 3) != 0);
      recv_idle = (phase != NumPhases - 1) && ($urandom_range(0, 3) != 0);
      if (phase == 0)
        for (i = 0; i < NumDirected; i++)
          queue_point(directed[i][0], directed[i][1], directed[i][2]);
      if (phase == 1) want_long_hold = 1'b1;
      for (i = 0; i < PhaseItems; i++)
        queue_point(pick_coord(), pick_coord(), pick_coord());
      // sender pauses until every measure of the phase is back
      wait_drained();
    end

    repeat (8) @(negedge clk_i);
    if (due_measures.size() != 0) begin
      $display("%0d measures never arrived", due_measures.size());
      fail_count += due_measures.size();
    end

    $display("Covered %0d points over %0d step writes, %0d measures checked.",
             points_accepted, steps_written, results_checked);
    $display("%0d saturated, %0d with corner planes off, %0d failures.",
             saturated_count, axis_only_count, fail_count);
    if (fail_count == 0) begin
      $display("truncated_cube_inside_measure_unit_test OK");
    end else begin
      $display("truncated_cube_inside_measure_unit_test NOT OK");
    end
    $finish;
  end

endmodule
